### rtl/i2crf_pkg.sv
// i2crf_pkg: shared types, register map and helper functions for the i2c register file
// used by i2c_register_file_hbridge_pwm_top; depends on nothing else
package i2crf_pkg;

    // bus event codes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    // update kinds on the result channel
    localparam logic [1:0] UPD_NONE   = 2'd0;
    localparam logic [1:0] UPD_BRIDGE = 2'd1;
    localparam logic [1:0] UPD_HEATER = 2'd2;
    localparam logic [1:0] UPD_IR     = 2'd3;

    // register map
    localparam logic [7:0] ADDR_API_MAJOR = 8'h00;
    localparam logic [7:0] ADDR_API_MINOR = 8'h01;
    localparam logic [7:0] ADDR_FW_MAJOR  = 8'h02;
    localparam logic [7:0] ADDR_FW_MINOR  = 8'h03;
    localparam logic [7:0] ADDR_STATUS    = 8'h04;
    localparam logic [7:0] ADDR_CAPS_LO   = 8'h05;
    localparam logic [7:0] ADDR_CAPS_HI   = 8'h06;
    localparam logic [7:0] BRIDGE_FIRST   = 8'h08;
    localparam logic [7:0] BRIDGE_LAST    = 8'h0B;
    localparam logic [7:0] HEATER_ADDR    = 8'h0C;
    localparam logic [7:0] IR_FIRST       = 8'h0D;
    localparam logic [7:0] IR_LAST        = 8'h10;
    localparam logic [7:0] TELE_FIRST     = 8'h11;
    localparam logic [7:0] TELE_LAST      = 8'h18;

    localparam logic [7:0]  API_MAJOR = 8'd1;
    localparam logic [7:0]  API_MINOR = 8'd0;
    localparam logic [7:0]  FW_MAJOR  = 8'd1;
    localparam logic [7:0]  FW_MINOR  = 8'd0;
    localparam logic [15:0] CAPS_MASK = 16'h0080;
    localparam logic [7:0]  UNMAPPED  = 8'hFF;

    localparam int NUM_CH   = 4;
    localparam int NUM_TELE = 8;

    typedef logic [NUM_CH-1:0][7:0]   chan_bytes_t;
    typedef logic [NUM_TELE-1:0][7:0] tele_bytes_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         bus_byte;
        logic [11:0]        board_id_adc;
        logic [11:0]        supply_adc;
        logic [15:0]        fan_rpm;
        logic signed [15:0] heater_temperature;
        logic               alert_level;
        logic               hall_level;
        logic               rpm_valid;
        logic               temperature_valid;
    } in_item_t;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_byte;
        logic [1:0] update_kind;
        logic [1:0] update_channel;
        logic [7:0] first_level;
        logic [7:0] second_level;
    } out_item_t;

    typedef struct packed {
        logic [7:0] first_level;
        logic [7:0] second_level;
    } bridge_lvl_t;

    // telemetry bytes, little endian words
    function automatic tele_bytes_t make_snapshot(input in_item_t it);
        tele_bytes_t t;
        t[0] = it.board_id_adc[7:0];
        t[1] = {4'h0, it.board_id_adc[11:8]};
        t[2] = it.supply_adc[7:0];
        t[3] = {4'h0, it.supply_adc[11:8]};
        t[4] = it.fan_rpm[7:0];
        t[5] = it.fan_rpm[15:8];
        t[6] = it.heater_temperature[7:0];
        t[7] = it.heater_temperature[15:8];
        return t;
    endfunction

    function automatic logic [7:0] status_byte(input in_item_t it);
        return {4'h0, it.temperature_valid, it.rpm_valid, it.hall_level, ~it.alert_level};
    endfunction

    // coast, brake, or forward/reverse with slow-decay duty
    function automatic bridge_lvl_t bridge_levels(input logic [7:0] v);
        bridge_lvl_t r;
        logic [7:0]  lvl;
        lvl = 8'hFF - {v[6:0], 1'b0};
        if (v == 8'h00) begin
            r = '{first_level: 8'h00, second_level: 8'h00};
        end else if (v == 8'hFF) begin
            r = '{first_level: 8'hFF, second_level: 8'hFF};
        end else if (v[7]) begin
            r = '{first_level: lvl, second_level: 8'hFF};
        end else begin
            r = '{first_level: 8'hFF, second_level: lvl};
        end
        return r;
    endfunction

endpackage

### rtl/i2c_register_file_hbridge_pwm_top.sv
// i2c_register_file_hbridge_pwm_top: register file behind an i2c target, one bus event per item
// depends on i2crf_pkg for payload types, register map and level functions
//
//   channel | ports                      | payload
//   --------+----------------------------+-----------------------------
//   events  | s_valid, s_ready, s_data   | in_item_t (mode, bus byte, sensors)
//   results | m_valid, m_ready, m_data   | out_item_t (read byte, drive update)
//
// an event is captured in an input register, decoded combinationally and lands in
// the result register; throughput is one event per cycle while m_ready stays high.
// aresetn is synchronous active low; it clears the pointer, settings and snapshot.
// when m_ready is low the result register holds and one more event is buffered
// in the input register before s_ready drops.
module i2c_register_file_hbridge_pwm_top
    import i2crf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic        in_valid_reg, in_valid_next;
    in_item_t    in_data_reg;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    logic [7:0]  ptr_reg, ptr_next;
    logic        await_reg, await_next;
    chan_bytes_t bridge_reg, bridge_next;
    logic [7:0]  heater_reg, heater_next;
    chan_bytes_t ir_reg, ir_next;
    tele_bytes_t tele_reg, tele_next;

    logic        advance;
    logic        fire;
    logic [7:0]  wr_byte;
    logic [7:0]  bridge_off, ir_off, tele_off;
    logic [7:0]  rd_byte;
    bridge_lvl_t lvls;
    tele_bytes_t fresh_tele;

    assign advance = !m_valid_reg || m_ready;
    assign fire    = advance && in_valid_reg;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign wr_byte    = in_data_reg.bus_byte;
    assign bridge_off = ptr_reg - BRIDGE_FIRST;
    assign ir_off     = ptr_reg - IR_FIRST;
    assign tele_off   = ptr_reg - TELE_FIRST;
    assign lvls       = bridge_levels(wr_byte);
    assign fresh_tele = make_snapshot(in_data_reg);

    // read mux; a read at the first telemetry register sees the fresh sample
    always_comb begin
        rd_byte = UNMAPPED;
        case (ptr_reg)
            ADDR_API_MAJOR: rd_byte = API_MAJOR;
            ADDR_API_MINOR: rd_byte = API_MINOR;
            ADDR_FW_MAJOR:  rd_byte = FW_MAJOR;
            ADDR_FW_MINOR:  rd_byte = FW_MINOR;
            ADDR_STATUS:    rd_byte = status_byte(in_data_reg);
            ADDR_CAPS_LO:   rd_byte = CAPS_MASK[7:0] | 8'h7F;
            ADDR_CAPS_HI:   rd_byte = 8'h00;
            HEATER_ADDR:    rd_byte = heater_reg;
            TELE_FIRST:     rd_byte = fresh_tele[0];
            default: begin
                if (ptr_reg >= BRIDGE_FIRST && ptr_reg <= BRIDGE_LAST) begin
                    rd_byte = bridge_reg[bridge_off[1:0]];
                end else if (ptr_reg >= IR_FIRST && ptr_reg <= IR_LAST) begin
                    rd_byte = ir_reg[ir_off[1:0]];
                end else if (ptr_reg >= TELE_FIRST && ptr_reg <= TELE_LAST) begin
                    rd_byte = tele_reg[tele_off[2:0]];
                end
            end
        endcase
    end

    always_comb begin
        ptr_next    = ptr_reg;
        await_next  = await_reg;
        bridge_next = bridge_reg;
        heater_next = heater_reg;
        ir_next     = ir_reg;
        tele_next   = tele_reg;
        m_data_next = '0;

        if (fire) begin
            case (in_data_reg.mode)
                MODE_WRITE: begin
                    if (await_reg) begin
                        ptr_next   = wr_byte;
                        await_next = 1'b0;
                        if (wr_byte >= TELE_FIRST && wr_byte <= TELE_LAST) begin
                            tele_next = fresh_tele;
                        end
                    end else begin
                        if (ptr_reg >= BRIDGE_FIRST && ptr_reg <= BRIDGE_LAST) begin
                            bridge_next[bridge_off[1:0]] = wr_byte;
                            m_data_next.update_kind      = UPD_BRIDGE;
                            m_data_next.update_channel   = bridge_off[1:0];
                            m_data_next.first_level      = lvls.first_level;
                            m_data_next.second_level     = lvls.second_level;
                        end else if (ptr_reg == HEATER_ADDR) begin
                            heater_next             = wr_byte;
                            m_data_next.update_kind = UPD_HEATER;
                            m_data_next.first_level = wr_byte;
                        end else if (ptr_reg >= IR_FIRST && ptr_reg <= IR_LAST) begin
                            ir_next[ir_off[1:0]]       = wr_byte;
                            m_data_next.update_kind    = UPD_IR;
                            m_data_next.update_channel = ir_off[1:0];
                            m_data_next.first_level    = wr_byte;
                        end
                        // unmapped writes drop the byte but still advance
                        ptr_next = ptr_reg + 8'd1;
                    end
                end
                MODE_READ: begin
                    if (ptr_reg == TELE_FIRST) begin
                        tele_next = fresh_tele;
                    end
                    m_data_next.read_valid = 1'b1;
                    m_data_next.read_byte  = rd_byte;
                    ptr_next               = ptr_reg + 8'd1;
                end
                MODE_STOP: begin
                    await_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        m_valid_next = advance ? in_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            ptr_reg      <= '0;
            await_reg    <= 1'b1;
            bridge_reg   <= '0;
            heater_reg   <= '0;
            ir_reg       <= '0;
            tele_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            ptr_reg      <= ptr_next;
            await_reg    <= await_next;
            bridge_reg   <= bridge_next;
            heater_reg   <= heater_next;
            ir_reg       <= ir_next;
            tele_reg     <= tele_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // a result never carries both a read answer and a drive update
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.read_valid || m_data.update_kind == UPD_NONE))
        else $error("read answer and drive update in one result");

    // without an update the level fields stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.update_kind == UPD_NONE) |->
        (m_data.first_level == 8'h00 && m_data.second_level == 8'h00))
        else $error("levels set without an update");

    // a processed stop always re-arms the pointer phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_data_reg.mode == MODE_STOP) |=> await_reg)
        else $error("stop did not re-arm pointer phase");

    // a read or data write always advances the pointer by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (in_data_reg.mode == MODE_READ ||
                  (in_data_reg.mode == MODE_WRITE && !await_reg)))
        |=> ptr_reg == $past(ptr_reg) + 8'd1)
        else $error("pointer did not advance");

    // input stage only blocks when both stages hold items
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg))
        else $error("input stalled with free space");

endmodule

### tb/i2crf_checker.sv
// i2crf_checker: watches both channels of the i2c register file, predicts every reply
// from its own copy of the pointer, settings and telemetry snapshot, and counts mismatches
// depends on i2crf_pkg for the payload types, event codes and register map
module i2crf_checker
    import i2crf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    output int unsigned mismatch_count,
    output int unsigned replies_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted register file state
    logic [7:0] reg_ptr;
    logic       await_ptr;
    logic [7:0] bridge_set [NUM_CH];
    logic [7:0] heater_set;
    logic [7:0] ir_set [NUM_CH];
    logic [7:0] tele_snap [NUM_TELE];

    out_item_t   bus_replies_q [$];
    out_item_t   want;
    int unsigned fails;

    task automatic latch_telemetry(input in_item_t ev);
        tele_snap[0] = ev.board_id_adc[7:0];
        tele_snap[1] = {4'h0, ev.board_id_adc[11:8]};
        tele_snap[2] = ev.supply_adc[7:0];
        tele_snap[3] = {4'h0, ev.supply_adc[11:8]};
        tele_snap[4] = ev.fan_rpm[7:0];
        tele_snap[5] = ev.fan_rpm[15:8];
        tele_snap[6] = ev.heater_temperature[7:0];
        tele_snap[7] = ev.heater_temperature[15:8];
    endtask

    task automatic decode_bus_event(input in_item_t ev, output out_item_t res);
        logic [7:0] offs;
        logic [7:0] lvl;
        logic [15:0] caps;
        res = '0;
        case (ev.mode)
            MODE_WRITE: begin
                if (await_ptr) begin
                    reg_ptr   = ev.bus_byte;
                    await_ptr = 1'b0;
                    if (ev.bus_byte >= TELE_FIRST && ev.bus_byte <= TELE_LAST) begin
                        latch_telemetry(ev);
                    end
                end else begin
                    if (reg_ptr >= BRIDGE_FIRST && reg_ptr <= BRIDGE_LAST) begin
                        offs = reg_ptr - BRIDGE_FIRST;
                        bridge_set[offs[1:0]] = ev.bus_byte;
                        res.update_kind    = UPD_BRIDGE;
                        res.update_channel = offs[1:0];
                        lvl = 8'd255 - {ev.bus_byte[6:0], 1'b0};
                        if (ev.bus_byte == 8'h00) begin
                            res.first_level  = 8'h00;
                            res.second_level = 8'h00;
                        end else if (ev.bus_byte == 8'hFF) begin
                            res.first_level  = 8'hFF;
                            res.second_level = 8'hFF;
                        end else if (ev.bus_byte[7]) begin
                            // reverse
                            res.first_level  = lvl;
                            res.second_level = 8'hFF;
                        end else begin
                            res.first_level  = 8'hFF;
                            res.second_level = lvl;
                        end
                    end else if (reg_ptr == HEATER_ADDR) begin
                        heater_set        = ev.bus_byte;
                        res.update_kind   = UPD_HEATER;
                        res.first_level   = ev.bus_byte;
                    end else if (reg_ptr >= IR_FIRST && reg_ptr <= IR_LAST) begin
                        offs = reg_ptr - IR_FIRST;
                        ir_set[offs[1:0]]  = ev.bus_byte;
                        res.update_kind    = UPD_IR;
                        res.update_channel = offs[1:0];
                        res.first_level    = ev.bus_byte;
                    end
                    // dropped writes still advance the pointer
                    reg_ptr = reg_ptr + 8'd1;
                end
            end
            MODE_READ: begin
                if (reg_ptr == TELE_FIRST) begin
                    latch_telemetry(ev);
                end
                res.read_valid = 1'b1;
                caps = CAPS_MASK | 16'h007F;
                if (reg_ptr >= BRIDGE_FIRST && reg_ptr <= BRIDGE_LAST) begin
                    offs = reg_ptr - BRIDGE_FIRST;
                    res.read_byte = bridge_set[offs[1:0]];
                end else if (reg_ptr == HEATER_ADDR) begin
                    res.read_byte = heater_set;
                end else if (reg_ptr >= IR_FIRST && reg_ptr <= IR_LAST) begin
                    offs = reg_ptr - IR_FIRST;
                    res.read_byte = ir_set[offs[1:0]];
                end else if (reg_ptr >= TELE_FIRST && reg_ptr <= TELE_LAST) begin
                    offs = reg_ptr - TELE_FIRST;
                    res.read_byte = tele_snap[offs[2:0]];
                end else begin
                    case (reg_ptr)
                        ADDR_API_MAJOR: res.read_byte = API_MAJOR;
                        ADDR_API_MINOR: res.read_byte = API_MINOR;
                        ADDR_FW_MAJOR:  res.read_byte = FW_MAJOR;
                        ADDR_FW_MINOR:  res.read_byte = FW_MINOR;
                        ADDR_STATUS: begin
                            res.read_byte = {4'h0, ev.temperature_valid, ev.rpm_valid,
                                             ev.hall_level, ~ev.alert_level};
                        end
                        ADDR_CAPS_LO:   res.read_byte = caps[7:0];
                        ADDR_CAPS_HI:   res.read_byte = 8'h00;
                        default:        res.read_byte = UNMAPPED;
                    endcase
                end
                reg_ptr = reg_ptr + 8'd1;
            end
            MODE_STOP: begin
                await_ptr = 1'b1;
            end
            default: begin
                // unused code, nothing changes
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reg_ptr    = 8'h00;
            await_ptr  = 1'b1;
            heater_set = 8'h00;
            for (int i = 0; i < NUM_CH; i++) begin
                bridge_set[i] = 8'h00;
                ir_set[i]     = 8'h00;
            end
            for (int i = 0; i < NUM_TELE; i++) begin
                tele_snap[i] = 8'h00;
            end
            bus_replies_q.delete();
            fails = 0;
        end else begin
            // a result leaves only after its event has passed the input and result registers, so pop before push
            if (m_valid && m_ready) begin
                if (bus_replies_q.size() == 0) begin
                    $error("result transfer with no event outstanding: 0x%0h", m_data);
                    fails++;
                end else begin
                    want = bus_replies_q.pop_front();
                    check_field("read_valid", 8'(want.read_valid), 8'(m_data.read_valid));
                    check_field("read_byte", want.read_byte, m_data.read_byte);
                    check_field("update_kind", 8'(want.update_kind), 8'(m_data.update_kind));
                    check_field("update_channel", 8'(want.update_channel),
                                8'(m_data.update_channel));
                    check_field("first_level", want.first_level, m_data.first_level);
                    check_field("second_level", want.second_level, m_data.second_level);
                end
            end
            if (s_valid && s_ready) begin
                decode_bus_event(s_data, want);
                bus_replies_q.push_back(want);
            end
        end
        mismatch_count <= fails;
        replies_owed   <= bus_replies_q.size();
    end

endmodule

### tb/i2c_register_file_hbridge_pwm_top_tb.sv
// i2c_register_file_hbridge_pwm_top_tb: drives bus events into the register file and
// toggles result backpressure; replies are checked by i2crf_checker beside the block
// depends on i2crf_pkg, i2crf_checker and i2c_register_file_hbridge_pwm_top
module i2c_register_file_hbridge_pwm_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import i2crf_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_EVENTS = 500;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 16;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int unsigned mismatch_count;
    int unsigned replies_owed;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          sent_count     = 0;
    int          cycle_count    = 0;

    always #1 aclk = ~aclk;

    i2c_register_file_hbridge_pwm_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    i2crf_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .replies_owed   (replies_owed)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic in_item_t make_event(input logic [1:0] mode, input logic [7:0] b);
        in_item_t ev;
        ev.mode               = mode;
        ev.bus_byte           = b;
        ev.board_id_adc       = 12'($urandom);
        ev.supply_adc         = 12'($urandom);
        ev.fan_rpm            = 16'($urandom);
        ev.heater_temperature = 16'($urandom);
        ev.alert_level        = 1'($urandom);
        ev.hall_level         = 1'($urandom);
        ev.rpm_valid          = 1'($urandom);
        ev.temperature_valid  = 1'($urandom);
        return ev;
    endfunction

    // call right after a rising edge; returns right after the edge of the transfer
    task automatic send_event(input in_item_t ev);
        int gap;
        bit taken;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        if (ev.mode != MODE_UNUSED) sent_count++;
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly stop, pointer, then a burst of reads or writes; the rest is loose noise
    task automatic send_transaction();
        int         len;
        bit         reading;
        logic [7:0] ptr;
        logic [1:0] md;
        if ($urandom_range(99) < 75) begin
            send_event(make_event(MODE_STOP, 8'($urandom)));
            case ($urandom_range(3))
                0:       ptr = 8'($urandom_range(8'h1A));
                1:       ptr = 8'($urandom_range(TELE_LAST, BRIDGE_FIRST));
                2:       ptr = TELE_FIRST;
                default: ptr = 8'($urandom);
            endcase
            send_event(make_event(MODE_WRITE, ptr));
            len     = $urandom_range(6, 1);
            reading = 1'($urandom);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(99) < 15) begin
                    md = 2'($urandom);
                end else begin
                    md = reading ? MODE_READ : MODE_WRITE;
                end
                send_event(make_event(md, pick_data()));
            end
        end else begin
            send_event(make_event(2'($urandom), 8'($urandom)));
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        in_item_t ev;
        int       target;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // after reset the first byte is the pointer: bridge drive extremes
        send_event(make_event(MODE_WRITE, BRIDGE_FIRST));
        send_event(make_event(MODE_WRITE, 8'h00));
        send_event(make_event(MODE_WRITE, 8'hFF));
        send_event(make_event(MODE_WRITE, 8'h7F));
        send_event(make_event(MODE_WRITE, 8'h80));
        // pointer runs on into heater and infrared
        send_event(make_event(MODE_WRITE, 8'hA5));
        send_event(make_event(MODE_WRITE, 8'h01));
        send_event(make_event(MODE_WRITE, 8'hFE));
        send_event(make_event(MODE_WRITE, 8'h55));
        send_event(make_event(MODE_WRITE, 8'hAA));
        // status, capabilities and an unmapped hole
        send_event(make_event(MODE_STOP, 8'h00));
        send_event(make_event(MODE_WRITE, ADDR_STATUS));
        send_event(make_event(MODE_READ, 8'h00));
        send_event(make_event(MODE_READ, 8'h00));
        send_event(make_event(MODE_READ, 8'h00));
        send_event(make_event(MODE_READ, 8'h00));
        // snapshot taken when the pointer lands in telemetry, all sensor bits high
        send_event(make_event(MODE_STOP, 8'hFF));
        ev = make_event(MODE_WRITE, TELE_FIRST + 8'd2);
        {ev.board_id_adc, ev.supply_adc, ev.fan_rpm, ev.heater_temperature,
         ev.alert_level, ev.hall_level, ev.rpm_valid, ev.temperature_valid} = {60{1'b1}};
        send_event(ev);
        send_event(make_event(MODE_READ, 8'h00));
        send_event(make_event(MODE_READ, 8'h00));
        // snapshot taken by a read that reaches the first telemetry register
        send_event(make_event(MODE_STOP, 8'h00));
        send_event(make_event(MODE_WRITE, IR_LAST));
        send_event(make_event(MODE_READ, 8'h00));
        ev = make_event(MODE_READ, 8'h00);
        {ev.board_id_adc, ev.supply_adc, ev.fan_rpm, ev.heater_temperature,
         ev.alert_level, ev.hall_level, ev.rpm_valid, ev.temperature_valid} = {60{1'b0}};
        send_event(ev);
        // unmapped write at the top of the map, then the pointer wraps
        send_event(make_event(MODE_STOP, 8'h00));
        send_event(make_event(MODE_WRITE, 8'hFF));
        send_event(make_event(MODE_WRITE, 8'h12));
        send_event(make_event(MODE_READ, 8'h00));
        send_event(make_event(MODE_UNUSED, 8'h5A));

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 73;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 73;
                end
                default: begin
                    src_idle_pct   = 35;
                    sink_stall_pct = 35;
                end
            endcase
            target = sent_count + RANDOM_EVENTS / 4;
            while (sent_count < target) send_transaction();
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (replies_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && replies_owed == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
